// ===== design/htts_pkg.sv =====
package htts_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int TICK_WIDTH = 16;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam int ACTION_W = 2;
  localparam int DEL_W    = 3;
  localparam int TIME_W   = 16;
  localparam int KIND_W   = 3;
  localparam int OSLOT_W  = 4;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD      = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_DISPATCH = 2'd3
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_RUN_NOW       = 3'd0,
    KIND_RUN_COOP      = 3'd1,
    KIND_ADD_DONE      = 3'd2,
    KIND_DELETE_DONE   = 3'd3,
    KIND_TICK_DONE     = 3'd4,
    KIND_DISPATCH_DONE = 3'd5
  } kind_e;

  // Status codes double as the sticky error codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef logic [TICK_WIDTH-1:0] tick_t;

  typedef struct packed {
    logic  emit;
    kind_e kind;
    logic  valid_n;
    logic  coop_n;
    logic  pend_n;
    logic  mem_we;
    tick_t delay_n;
  } slot_upd_t;

endpackage

// ===== design/htts_if.sv =====
interface htts_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [htts_pkg::ACTION_W-1:0] action;
  logic [htts_pkg::DEL_W-1:0]    slot_to_delete;
  logic [htts_pkg::TIME_W-1:0]   first_delay;
  logic [htts_pkg::TIME_W-1:0]   repeat_period;
  logic                          cooperative;

  modport source (output valid, action, slot_to_delete, first_delay, repeat_period,
                  cooperative, input ready);
  modport sink   (input valid, action, slot_to_delete, first_delay, repeat_period,
                  cooperative, output ready);
endinterface

interface htts_res_if;
  logic                          valid;
  logic                          ready;
  logic [htts_pkg::KIND_W-1:0]   kind;
  logic [htts_pkg::OSLOT_W-1:0]  slot;
  logic [htts_pkg::STATUS_W-1:0] status;
  logic [htts_pkg::STATUS_W-1:0] last_error;
  logic                          last;

  modport source (output valid, kind, slot, status, last_error, last, input ready);
  modport sink   (input valid, kind, slot, status, last_error, last, output ready);
endinterface

// ===== design/htts_slot_eval.sv =====
module htts_slot_eval (
  input  logic               dispatch_i,
  input  logic               valid_i,
  input  logic               coop_i,
  input  logic               pend_i,
  input  htts_pkg::tick_t    delay_i,
  input  htts_pkg::tick_t    period_i,
  output htts_pkg::slot_upd_t upd_o
);
  import htts_pkg::*;

  always_comb begin
    upd_o.emit    = 1'b0;
    upd_o.kind    = KIND_RUN_NOW;
    upd_o.valid_n = valid_i;
    upd_o.coop_n  = coop_i;
    upd_o.pend_n  = pend_i;
    upd_o.mem_we  = 1'b0;
    upd_o.delay_n = delay_i;
    if (dispatch_i) begin
      if (valid_i && pend_i) begin
        upd_o.emit   = 1'b1;
        upd_o.kind   = KIND_RUN_COOP;
        upd_o.pend_n = 1'b0;
        // one-shot: drop the slot
        if (period_i == '0) begin
          upd_o.valid_n = 1'b0;
          upd_o.coop_n  = 1'b0;
        end
      end
    end else if (valid_i) begin
      upd_o.mem_we = 1'b1;
      if (delay_i == '0) begin
        if (coop_i) begin
          upd_o.pend_n = 1'b1;
        end else begin
          upd_o.emit   = 1'b1;
          upd_o.kind   = KIND_RUN_NOW;
          upd_o.pend_n = 1'b0;
          if (period_i == '0) begin
            upd_o.valid_n = 1'b0;
          end
        end
        if (period_i != '0) begin
          upd_o.delay_n = period_i;
        end
      end else begin
        upd_o.delay_n = delay_i - tick_t'(1);
      end
    end
  end

endmodule

// ===== design/hybrid_task_tick_scheduler_core.sv =====
// Add and delete: one result, loaded into the result register in the execute state that
// follows the accept state, once the result register is free or being taken.
// Tick and dispatch: the slot table memory is walked one slot per cycle while no run
// result waits on the result port; an item passes through the accept, a read-ahead of
// the first slot, one step per slot and the done beat, and stalls while ready is low.
// Reset clears slot flags, sticky error and control; the delay/period memory is
// not cleared, its entries are used only while their slot is marked valid.
module hybrid_task_tick_scheduler_core (
  input logic             clk_i,
  input logic             rst_ni,
  htts_cmd_if.sink        cmd_i,
  htts_res_if.source      res_o
);
  import htts_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic [SLOT_W-1:0] eval_q, eval_d;
  logic rd_ok_q, rd_ok_d;
  logic [TASK_SLOTS-1:0] valid_q, valid_d, coop_q, coop_d, pend_q, pend_d;
  status_e sticky_q, sticky_d;

  action_e action_q;
  logic [DEL_W-1:0] del_q;
  logic [TIME_W-1:0] fdelay_q, period_q;
  logic coop_in_q;

  logic [2*TICK_WIDTH-1:0] mem_q [TASK_SLOTS];
  logic [2*TICK_WIDTH-1:0] rdata_q, mem_wdata;
  logic mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  tick_t rd_delay, rd_period;

  logic out_valid_q;
  kind_e kind_q;
  logic [OSLOT_W-1:0] slot_q;
  status_e status_q, err_q;
  logic last_q;

  logic load, can_load, ld_last;
  kind_e ld_kind;
  logic [OSLOT_W-1:0] ld_slot;
  status_e ld_status;

  logic free_found;
  logic [SLOT_W-1:0] free_idx, del_idx;
  logic del_hit;
  slot_upd_t upd;

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign can_load    = !out_valid_q || res_o.ready;

  assign rd_delay  = rdata_q[TICK_WIDTH-1:0];
  assign rd_period = rdata_q[2*TICK_WIDTH-1 -: TICK_WIDTH];

  assign del_idx = SLOT_W'(del_q);
  assign del_hit = (int'(del_q) < TASK_SLOTS) && valid_q[del_idx];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  htts_slot_eval u_eval (
    .dispatch_i (action_q == ACT_DISPATCH),
    .valid_i    (valid_q[eval_q]),
    .coop_i     (coop_q[eval_q]),
    .pend_i     (pend_q[eval_q]),
    .delay_i    (rd_delay),
    .period_i   (rd_period),
    .upd_o      (upd)
  );

  always_comb begin
    state_d   = state_q;
    eval_d    = eval_q;
    rd_ok_d   = rd_ok_q;
    valid_d   = valid_q;
    coop_d    = coop_q;
    pend_d    = pend_q;
    sticky_d  = sticky_q;
    mem_we    = 1'b0;
    mem_waddr = eval_q;
    mem_wdata = {rd_period, upd.delay_n};
    mem_re    = 1'b0;
    mem_raddr = eval_q;
    load      = 1'b0;
    ld_kind   = KIND_RUN_NOW;
    ld_slot   = '0;
    ld_status = STATUS_OK;
    ld_last   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          if (action_e'(cmd_i.action) == ACT_ADD ||
              action_e'(cmd_i.action) == ACT_DELETE) begin
            state_d = ST_EXEC;
          end else begin
            state_d = ST_SCAN;
            eval_d  = '0;
            rd_ok_d = 1'b0;
          end
        end
      end

      ST_EXEC: begin
        if (can_load) begin
          load    = 1'b1;
          ld_last = 1'b1;
          state_d = ST_IDLE;
          if (action_q == ACT_ADD) begin
            ld_kind = KIND_ADD_DONE;
            if (free_found) begin
              valid_d[free_idx] = 1'b1;
              coop_d[free_idx]  = coop_in_q;
              pend_d[free_idx]  = 1'b0;
              mem_we    = 1'b1;
              mem_waddr = free_idx;
              mem_wdata = {TICK_WIDTH'(period_q), TICK_WIDTH'(fdelay_q)};
              ld_slot   = OSLOT_W'(free_idx);
            end else begin
              sticky_d  = STATUS_FULL;
              ld_slot   = OSLOT_W'(TASK_SLOTS);
              ld_status = STATUS_FULL;
            end
          end else begin
            ld_kind = KIND_DELETE_DONE;
            ld_slot = OSLOT_W'(del_q);
            if (del_hit) begin
              valid_d[del_idx] = 1'b0;
              coop_d[del_idx]  = 1'b0;
              pend_d[del_idx]  = 1'b0;
            end else begin
              sticky_d  = STATUS_EMPTY;
              ld_status = STATUS_EMPTY;
            end
          end
        end
      end

      ST_SCAN: begin
        if (!rd_ok_q) begin
          mem_re  = 1'b1;
          rd_ok_d = 1'b1;
        end else if (!upd.emit || can_load) begin
          valid_d[eval_q] = upd.valid_n;
          coop_d[eval_q]  = upd.coop_n;
          pend_d[eval_q]  = upd.pend_n;
          mem_we = upd.mem_we;
          if (upd.emit) begin
            load    = 1'b1;
            ld_kind = upd.kind;
            ld_slot = OSLOT_W'(eval_q);
          end
          if (eval_q == SLOT_W'(TASK_SLOTS - 1)) begin
            state_d = ST_DONE;
            rd_ok_d = 1'b0;
          end else begin
            // read ahead the next slot while this one writes back
            eval_d    = eval_q + SLOT_W'(1);
            mem_re    = 1'b1;
            mem_raddr = eval_q + SLOT_W'(1);
          end
        end
      end

      ST_DONE: begin
        if (can_load) begin
          load    = 1'b1;
          ld_last = 1'b1;
          ld_kind = (action_q == ACT_DISPATCH) ? KIND_DISPATCH_DONE : KIND_TICK_DONE;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      eval_q      <= '0;
      rd_ok_q     <= 1'b0;
      valid_q     <= '0;
      coop_q      <= '0;
      pend_q      <= '0;
      sticky_q    <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      eval_q   <= eval_d;
      rd_ok_q  <= rd_ok_d;
      valid_q  <= valid_d;
      coop_q   <= coop_d;
      pend_q   <= pend_d;
      sticky_q <= sticky_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      action_q  <= action_e'(cmd_i.action);
      del_q     <= cmd_i.slot_to_delete;
      fdelay_q  <= cmd_i.first_delay;
      period_q  <= cmd_i.repeat_period;
      coop_in_q <= cmd_i.cooperative;
    end
    if (load) begin
      kind_q   <= ld_kind;
      slot_q   <= ld_slot;
      status_q <= ld_status;
      err_q    <= sticky_d;
      last_q   <= ld_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.kind       = kind_q;
  assign res_o.slot       = slot_q;
  assign res_o.status     = status_q;
  assign res_o.last_error = err_q;
  assign res_o.last       = last_q;

endmodule

// ===== design/htts_checker.sv =====
module htts_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cmd_valid_i,
  input logic                          cmd_ready_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [htts_pkg::KIND_W-1:0]   res_kind_i,
  input logic [htts_pkg::OSLOT_W-1:0]  res_slot_i,
  input logic [htts_pkg::STATUS_W-1:0] res_status_i,
  input logic                          res_last_i
);
  import htts_pkg::*;

  // a result beat stays offered until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  // one command at a time
  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command accepted while busy");

  // only run results come before the closing beat
  a_run_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_last_i |->
      res_kind_i == KIND_RUN_NOW || res_kind_i == KIND_RUN_COOP)
    else $error("non-run result without last");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_ADD_DONE || res_kind_i == KIND_DELETE_DONE ||
      res_kind_i == KIND_TICK_DONE || res_kind_i == KIND_DISPATCH_DONE) |-> res_last_i)
    else $error("done result without last");

  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i == STATUS_FULL |->
      res_kind_i == KIND_ADD_DONE && res_slot_i == OSLOT_W'(TASK_SLOTS))
    else $error("table full reported on wrong result");

endmodule

bind hybrid_task_tick_scheduler_core htts_checker u_htts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_kind_i   (res_o.kind),
  .res_slot_i   (res_o.slot),
  .res_status_i (res_o.status),
  .res_last_i   (res_o.last)
);

// ===== tb/hybrid_task_tick_scheduler_core_tb.sv =====
module hybrid_task_tick_scheduler_core_tb;
  import htts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 120;

  typedef struct {
    action_e             action;
    logic [DEL_W-1:0]    slot_to_delete;
    logic [TIME_W-1:0]   first_delay;
    logic [TIME_W-1:0]   repeat_period;
    logic                cooperative;
  } sched_cmd_t;

  typedef struct {
    kind_e               kind;
    logic [OSLOT_W-1:0]  slot;
    status_e             status;
    status_e             err;
    logic                last;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n;

  htts_cmd_if cmd_bus ();
  htts_res_if res_bus ();

  hybrid_task_tick_scheduler_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow copy of the task table
  logic        slot_live [TASK_SLOTS];
  tick_t       countdown [TASK_SLOTS];
  tick_t       reload    [TASK_SLOTS];
  logic        coop_task [TASK_SLOTS];
  logic        run_req   [TASK_SLOTS];
  status_e     sticky_err;

  sched_cmd_t  cmd_queue[$];
  sched_res_t  due_results[$];

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  logic        hold_go   = 1'b0;
  int unsigned hold_left;
  int unsigned cycle_cnt = 0;

  int unsigned n_errors  = 0;
  int unsigned n_checked = 0;
  int unsigned n_runs    = 0;
  int unsigned n_full    = 0;
  int unsigned n_by_action [4] = '{default: 0};

  function automatic void post_result(kind_e k, int unsigned s, status_e st, logic fin);
    sched_res_t r;
    r.kind   = k;
    r.slot   = OSLOT_W'(s);
    r.status = st;
    r.err    = sticky_err;
    r.last   = fin;
    due_results.push_back(r);
    if (k == KIND_RUN_NOW || k == KIND_RUN_COOP) n_runs++;
  endfunction

  function automatic void clear_task(int unsigned i);
    slot_live[i] = 1'b0;
    countdown[i] = '0;
    reload[i]    = '0;
    coop_task[i] = 1'b0;
    run_req[i]   = 1'b0;
  endfunction

  function automatic void advance_task_table(sched_cmd_t c);
    int unsigned idx;
    idx = 0;
    n_by_action[c.action]++;
    case (c.action)
      ACT_ADD: begin
        while (idx < TASK_SLOTS && slot_live[idx]) idx++;
        if (idx == TASK_SLOTS) begin
          sticky_err = STATUS_FULL;
          n_full++;
          post_result(KIND_ADD_DONE, TASK_SLOTS, STATUS_FULL, 1'b1);
        end else begin
          slot_live[idx] = 1'b1;
          countdown[idx] = c.first_delay;
          reload[idx]    = c.repeat_period;
          coop_task[idx] = c.cooperative;
          run_req[idx]   = 1'b0;
          post_result(KIND_ADD_DONE, idx, STATUS_OK, 1'b1);
        end
      end
      ACT_DELETE: begin
        if (c.slot_to_delete >= TASK_SLOTS || !slot_live[c.slot_to_delete]) begin
          sticky_err = STATUS_EMPTY;
          post_result(KIND_DELETE_DONE, c.slot_to_delete, STATUS_EMPTY, 1'b1);
        end else begin
          clear_task(c.slot_to_delete);
          post_result(KIND_DELETE_DONE, c.slot_to_delete, STATUS_OK, 1'b1);
        end
      end
      ACT_TICK: begin
        for (int unsigned i = 0; i < TASK_SLOTS; i++) begin
          if (!slot_live[i]) continue;
          if (countdown[i] == '0) begin
            if (coop_task[i]) begin
              run_req[i] = 1'b1;
            end else begin
              post_result(KIND_RUN_NOW, i, STATUS_OK, 1'b0);
              run_req[i] = 1'b0;
              // one-shot preemptive: drop the slot but keep its timing fields
              if (reload[i] == '0) slot_live[i] = 1'b0;
            end
            if (reload[i] != '0) countdown[i] = reload[i];
          end else begin
            countdown[i] = countdown[i] - 1'b1;
          end
        end
        post_result(KIND_TICK_DONE, 0, STATUS_OK, 1'b1);
      end
      default: begin
        for (int unsigned i = 0; i < TASK_SLOTS; i++) begin
          if (!slot_live[i] || !run_req[i]) continue;
          post_result(KIND_RUN_COOP, i, STATUS_OK, 1'b0);
          run_req[i] = 1'b0;
          if (reload[i] == '0) clear_task(i);
        end
        post_result(KIND_DISPATCH_DONE, 0, STATUS_OK, 1'b1);
      end
    endcase
  endfunction

  task automatic queue_cmd(action_e a, int unsigned del, int unsigned fd, int unsigned per,
                           logic coop);
    sched_cmd_t c;
    c.action         = a;
    c.slot_to_delete = DEL_W'(del);
    c.first_delay    = TIME_W'(fd);
    c.repeat_period  = TIME_W'(per);
    c.cooperative    = coop;
    cmd_queue.push_back(c);
  endtask

  // Mostly short delays and periods so tasks fire often; a few extremes.
  task automatic queue_random(int unsigned count);
    int unsigned pick;
    int unsigned timing [2];
    action_e     a;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 30)      a = ACT_ADD;
      else if (pick < 45) a = ACT_DELETE;
      else if (pick < 80) a = ACT_TICK;
      else                a = ACT_DISPATCH;
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(9))
          0:       timing[k] = $urandom_range(16'hFFFF);
          1:       timing[k] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          default: timing[k] = $urandom_range(4);
        endcase
      end
      queue_cmd(a, $urandom_range(7), timing[0], timing[1], $urandom_range(1));
    end
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || cmd_bus.valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk or negedge rst_n) begin : drive_cmd
    sched_cmd_t nxt;
    if (!rst_n) begin
      cmd_bus.valid          <= 1'b0;
      cmd_bus.action         <= '0;
      cmd_bus.slot_to_delete <= '0;
      cmd_bus.first_delay    <= '0;
      cmd_bus.repeat_period  <= '0;
      cmd_bus.cooperative    <= 1'b0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        nxt.action         = action_e'(cmd_bus.action);
        nxt.slot_to_delete = cmd_bus.slot_to_delete;
        nxt.first_delay    = cmd_bus.first_delay;
        nxt.repeat_period  = cmd_bus.repeat_period;
        nxt.cooperative    = cmd_bus.cooperative;
        advance_task_table(nxt);
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
          nxt = cmd_queue.pop_front();
          cmd_bus.valid          <= 1'b1;
          cmd_bus.action         <= nxt.action;
          cmd_bus.slot_to_delete <= nxt.slot_to_delete;
          cmd_bus.first_delay    <= nxt.first_delay;
          cmd_bus.repeat_period  <= nxt.repeat_period;
          cmd_bus.cooperative    <= nxt.cooperative;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    sched_res_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      n_checked++;
      if (due_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected beat: kind %0d slot %0d status %0d err %0d last %0b",
                   res_bus.kind, res_bus.slot, res_bus.status, res_bus.last_error,
                   res_bus.last);
      end else begin
        want = due_results.pop_front();
        if (res_bus.kind !== want.kind || res_bus.slot !== want.slot ||
            res_bus.status !== want.status || res_bus.last_error !== want.err ||
            res_bus.last !== want.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected kind %0d slot %0d status %0d err %0d last %0b, got %0d %0d %0d %0d %0b",
                     want.kind, want.slot, want.status, want.err, want.last,
                     res_bus.kind, res_bus.slot, res_bus.status, res_bus.last_error,
                     res_bus.last);
        end
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still due", cycle_cnt, due_results.size());
    $display("hybrid_task_tick_scheduler_core_tb: done, errors");
    $finish;
  end

  initial begin : run_test
    rst_n                  = 1'b0;
    cmd_bus.valid          = 1'b0;
    cmd_bus.action         = '0;
    cmd_bus.slot_to_delete = '0;
    cmd_bus.first_delay    = '0;
    cmd_bus.repeat_period  = '0;
    cmd_bus.cooperative    = 1'b0;
    res_bus.ready          = 1'b0;
    for (int i = 0; i < TASK_SLOTS; i++) clear_task(i);
    sticky_err = STATUS_OK;
    repeat (7) @(posedge clk);
    rst_n     <= 1'b1;
    gap_pct   <= 12;
    stall_pct <= 72;

    // empty table: bare done beats, then an empty delete
    queue_cmd(ACT_DISPATCH, 0, 0, 0, 1'b0);
    queue_cmd(ACT_TICK, 0, 0, 0, 1'b0);
    queue_cmd(ACT_DELETE, 3, 0, 0, 1'b0);
    // fill every slot with a mix of one-shot, periodic and extreme timings
    queue_cmd(ACT_ADD, 0, 0, 0, 1'b0);
    queue_cmd(ACT_ADD, 0, 0, 0, 1'b1);
    queue_cmd(ACT_ADD, 0, 1, 2, 1'b0);
    queue_cmd(ACT_ADD, 0, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_cmd(ACT_ADD, 0, 0, 1, 1'b0);
    queue_cmd(ACT_ADD, 0, 1, 2, 1'b1);
    queue_cmd(ACT_ADD, 0, 16'hFFFF, 0, 1'b0);
    queue_cmd(ACT_ADD, 0, 0, 3, 1'b1);
    // table full
    queue_cmd(ACT_ADD, 7, 5, 5, 1'b0);
    queue_cmd(ACT_TICK, 0, 0, 0, 1'b0);
    queue_cmd(ACT_DISPATCH, 0, 0, 0, 1'b0);
    queue_cmd(ACT_TICK, 0, 0, 0, 1'b0);
    queue_cmd(ACT_TICK, 0, 0, 0, 1'b0);
    queue_cmd(ACT_DISPATCH, 0, 0, 0, 1'b0);
    queue_cmd(ACT_DELETE, 7, 0, 0, 1'b0);
    // slot 0 was a one-shot that already ran
    queue_cmd(ACT_DELETE, 0, 0, 0, 1'b0);
    queue_cmd(ACT_ADD, 0, 2, 0, 1'b1);
    queue_cmd(ACT_TICK, 0, 0, 0, 1'b0);
    queue_cmd(ACT_TICK, 0, 0, 0, 1'b0);
    queue_cmd(ACT_TICK, 0, 0, 0, 1'b0);
    queue_cmd(ACT_DISPATCH, 0, 0, 0, 1'b0);
    queue_cmd(ACT_TICK, 0, 0, 0, 1'b0);
    wait_drained();

    queue_random(PHASE_ITEMS);
    wait_drained();

    gap_pct   <= 72;
    stall_pct <= 12;
    queue_random(PHASE_ITEMS);
    wait_drained();

    // no idling; hold the result port off long enough to back up the command port
    gap_pct   <= 0;
    stall_pct <= 0;
    hold_go   <= 1'b1;
    @(posedge clk);
    hold_go   <= 1'b0;
    queue_random(PHASE_ITEMS);
    wait_drained();

    repeat (4 * TASK_SLOTS) @(posedge clk);
    $display("covered %0d adds (%0d rejected full), %0d deletes, %0d ticks, %0d dispatches",
             n_by_action[ACT_ADD], n_full, n_by_action[ACT_DELETE],
             n_by_action[ACT_TICK], n_by_action[ACT_DISPATCH]);
    $display("checked %0d result beats, %0d task runs, %0d mismatches",
             n_checked, n_runs, n_errors);
    if (n_errors == 0 && due_results.size() == 0) begin
      $display("hybrid_task_tick_scheduler_core_tb: done, clean");
    end else begin
      $display("hybrid_task_tick_scheduler_core_tb: done, errors");
    end
    $finish;
  end

endmodule
